FILE: hw/rtl/srtl_pkg.sv
// shared types and constants for the sorted range table lookup
// no dependencies; every other file of the block but srtl_ram refers to this package

package srtl_pkg;

    localparam int unsigned MAX_RANGES = 256;
    localparam int unsigned TAG_BITS   = 16;

    // fixed field widths of the channels
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned SLOT_W     = 8;
    localparam int unsigned TAG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    // table index, search bound and number of probe cells
    localparam int unsigned IDX_W     = $clog2(MAX_RANGES);
    localparam int unsigned CNT_W     = $clog2(MAX_RANGES + 1);
    localparam int unsigned NUM_CELLS = CNT_W;

    localparam int unsigned ENTRY_W = 2 * ADDR_W + TAG_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT   = 1'b0,
        REG_CLEAR_LOW_BIT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // one item travelling down the cell chain
    typedef struct packed {
        logic                lookup;
        logic                wr_ok;
        logic                done;
        logic                hit;
        logic [CNT_W-1:0]    lo;
        logic [CNT_W-1:0]    hip1;
        logic [IDX_W-1:0]    pos;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   key;
        logic [ADDR_W-1:0]   high;
        logic [TAG_BITS-1:0] tag;
    } item_t;

endpackage

FILE: hw/rtl/srtl_req_if.sv
// input channel of the sorted range table lookup: valid/ready plus item fields
// depends on srtl_pkg for the field widths

interface srtl_req_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [srtl_pkg::SLOT_W-1:0]       entry_index;
    logic [srtl_pkg::ADDR_W-1:0]       range_low;
    logic [srtl_pkg::ADDR_W-1:0]       range_high;
    logic [srtl_pkg::TAG_W-1:0]        library_tag;
    logic [srtl_pkg::ADDR_W-1:0]       address;

    modport source (
        output valid, operation, entry_index, range_low, range_high, library_tag, address,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_index, range_low, range_high, library_tag, address,
        output ready
    );
endinterface

FILE: hw/rtl/srtl_rsp_if.sv
// result channel of the sorted range table lookup: valid/ready plus result fields
// depends on srtl_pkg for the field widths

interface srtl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [srtl_pkg::SLOT_W-1:0]   found_index;
    logic [srtl_pkg::TAG_W-1:0]    found_tag;

    modport source (
        output valid, hit, found_index, found_tag,
        input  ready
    );

    modport sink (
        input  valid, hit, found_index, found_tag,
        output ready
    );
endinterface

FILE: hw/rtl/srtl_ram.sv
// generic single write port ram with registered read
// no package dependency

module srtl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/srtl_cell.sv
// one probe cell: a full copy of the table and one binary search step
// depends on srtl_pkg and srtl_ram

module srtl_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  srtl_pkg::item_t up_item,
    output logic            up_ready,
    output logic            dn_valid,
    output srtl_pkg::item_t dn_item,
    input  logic            dn_ready
);

    // issue stage: address the local table copy
    logic                      p_valid_reg;
    logic                      p_valid_next;
    srtl_pkg::item_t           p_item_reg;
    // compare stage: table word arrives from the ram
    logic                      q_valid_reg;
    logic                      q_valid_next;
    logic                      q_probe_reg;
    srtl_pkg::item_t           q_item_reg;
    srtl_pkg::item_t           q_item_next;

    logic                      q_free;
    logic                      p_free;
    logic                      p_go;
    logic                      p_active;
    logic [srtl_pkg::CNT_W-1:0] span;
    logic [srtl_pkg::CNT_W-1:0] mid_wide;
    logic [srtl_pkg::IDX_W-1:0] mid;
    logic                      ram_we;
    logic                      ram_re;
    logic [srtl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [srtl_pkg::ENTRY_W-1:0] ram_rdata;
    logic [srtl_pkg::ADDR_W-1:0]  ent_low;
    logic [srtl_pkg::ADDR_W-1:0]  ent_high;
    logic [srtl_pkg::TAG_BITS-1:0] ent_tag;
    srtl_pkg::item_t           res_item;

    assign q_free   = !q_valid_reg || dn_ready;
    assign p_free   = !p_valid_reg || q_free;
    assign p_go     = p_valid_reg && q_free;
    assign up_ready = p_free;

    // a probe only while the interval lo..hi is not empty
    assign p_active = p_item_reg.lookup && !p_item_reg.done
                      && (p_item_reg.lo < p_item_reg.hip1);
    assign span     = (p_item_reg.hip1 - p_item_reg.lo - 1'b1) >> 1;
    assign mid_wide = p_item_reg.lo + span;
    assign mid      = mid_wide[srtl_pkg::IDX_W-1:0];

    assign ram_we    = p_go && !p_item_reg.lookup && p_item_reg.wr_ok;
    assign ram_re    = p_go && p_active;
    assign ram_wdata = {p_item_reg.key, p_item_reg.high, p_item_reg.tag};

    srtl_ram #(
        .WIDTH (srtl_pkg::ENTRY_W),
        .DEPTH (srtl_pkg::MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (srtl_pkg::IDX_W'(p_item_reg.slot)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (mid),
        .rdata (ram_rdata)
    );

    assign {ent_low, ent_high, ent_tag} = ram_rdata;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (p_free)
        begin
            p_valid_next = up_valid;
        end

        q_valid_next = q_valid_reg;
        if (q_free)
        begin
            q_valid_next = p_valid_reg;
        end

        q_item_next = p_item_reg;
        if (p_active)
        begin
            q_item_next.pos = mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && up_valid)
        begin
            p_item_reg <= up_item;
        end
        if (p_go)
        begin
            q_item_reg  <= q_item_next;
            q_probe_reg <= p_active;
        end
    end

    // narrow the interval or stop on a hit
    always_comb
    begin
        res_item = q_item_reg;
        if (q_probe_reg)
        begin
            if (q_item_reg.key < ent_low)
            begin
                res_item.hip1 = srtl_pkg::CNT_W'(q_item_reg.pos);
            end
            else if (q_item_reg.key >= ent_high)
            begin
                res_item.lo = srtl_pkg::CNT_W'(q_item_reg.pos) + 1'b1;
            end
            else
            begin
                res_item.done = 1'b1;
                res_item.hit  = 1'b1;
                res_item.tag  = ent_tag;
            end
        end
    end

    assign dn_valid = q_valid_reg;
    assign dn_item  = res_item;

endmodule

FILE: hw/rtl/sorted_range_table_lookup.sv
// top level of the sorted range table lookup: config registers, chain of probe cells,
// result register; depends on srtl_pkg, srtl_req_if, srtl_rsp_if and srtl_cell
//
//   channel   kind           fields
//   req       valid/ready    operation, entry_index, range_low, range_high,
//                            library_tag, address
//   rsp       valid/ready    hit, found_index, found_tag
//   cfg       write only     cfg_write, cfg_index, cfg_data
//
// every item walks the chain of NUM_CELLS cells, two registers per cell; lookups then
// reach the result register. each cell holds its own copy of the table; a write updates
// each copy as it passes, so a new item is taken every cycle unless the chain stalls,
// and items stay in order. a stalled result only holds the cells that are full;
// empty slots close up.
// reset clears the config registers and all valid flags; the tables are undefined.

module sorted_range_table_lookup (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [srtl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srtl_pkg::CFG_DATA_W-1:0]   cfg_data,
    srtl_req_if.sink                          req,
    srtl_rsp_if.source                        rsp
);

    logic [srtl_pkg::CFG_DATA_W-1:0] entry_count_reg;
    logic                            clear_low_bit_reg;

    logic [srtl_pkg::CNT_W-1:0]      count_clamped;
    logic [srtl_pkg::ADDR_W-1:0]     search_key;
    srtl_pkg::item_t                 entry_item;

    srtl_pkg::item_t                 chain_item  [srtl_pkg::NUM_CELLS+1];
    logic                            chain_valid [srtl_pkg::NUM_CELLS+1];
    logic                            chain_ready [srtl_pkg::NUM_CELLS+1];

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_hit_reg;
    logic [srtl_pkg::SLOT_W-1:0]     out_index_reg;
    logic [srtl_pkg::TAG_W-1:0]      out_tag_reg;
    logic                            out_free;
    logic                            out_load;
    srtl_pkg::item_t                 last_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg   <= '0;
            clear_low_bit_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (srtl_pkg::cfg_reg_t'(cfg_index))
                srtl_pkg::REG_ENTRY_COUNT:   entry_count_reg   <= cfg_data;
                srtl_pkg::REG_CLEAR_LOW_BIT: clear_low_bit_reg <= cfg_data[0];
                default:                     entry_count_reg   <= entry_count_reg;
            endcase
        end
    end

    // build the chain item from the request
    always_comb
    begin
        if (32'(entry_count_reg) > srtl_pkg::MAX_RANGES)
        begin
            count_clamped = srtl_pkg::CNT_W'(srtl_pkg::MAX_RANGES);
        end
        else
        begin
            count_clamped = srtl_pkg::CNT_W'(entry_count_reg);
        end

        search_key = req.address;
        if (clear_low_bit_reg)
        begin
            search_key[0] = 1'b0;
        end

        entry_item        = '0;
        entry_item.lookup = (srtl_pkg::op_t'(req.operation) == srtl_pkg::OP_LOOKUP);
        entry_item.slot   = req.entry_index;
        entry_item.wr_ok  = (32'(req.entry_index) < srtl_pkg::MAX_RANGES);
        entry_item.high   = req.range_high;
        entry_item.hip1   = count_clamped;
        if (entry_item.lookup)
        begin
            entry_item.key  = search_key;
            // zero address is a miss before any probe
            entry_item.done = (req.address == '0);
        end
        else
        begin
            entry_item.key = req.range_low;
            entry_item.tag = srtl_pkg::TAG_BITS'(req.library_tag);
        end
    end

    assign chain_item[0]  = entry_item;
    assign chain_valid[0] = req.valid;
    assign req.ready      = chain_ready[0];

    for (genvar g = 0; g < srtl_pkg::NUM_CELLS; g++)
    begin : g_cell
        srtl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_item  (chain_item[g]),
            .up_ready (chain_ready[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_item  (chain_item[g+1]),
            .dn_ready (chain_ready[g+1])
        );
    end

    // writes leave the chain here, lookups go to the result register
    assign last_item = chain_item[srtl_pkg::NUM_CELLS];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign chain_ready[srtl_pkg::NUM_CELLS] = out_free || !last_item.lookup;
    assign out_load  = chain_valid[srtl_pkg::NUM_CELLS] && last_item.lookup && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = out_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg   <= last_item.hit;
            out_index_reg <= last_item.hit ? srtl_pkg::SLOT_W'(last_item.pos) : '0;
            out_tag_reg   <= last_item.hit ? srtl_pkg::TAG_W'(last_item.tag) : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.found_index = out_index_reg;
    assign rsp.found_tag   = out_tag_reg;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for sorted_range_table_lookup: table fills, directed and random lookups
// depends on srtl_pkg, srtl_req_if, srtl_rsp_if and the block's rtl; a scoreboard class predicts the results

module testbench;

    localparam int unsigned LATENCY      = 2 * srtl_pkg::NUM_CELLS + 1;
    localparam int unsigned SETTLE_CYCLE = LATENCY + 4;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic                        hit;
        logic [srtl_pkg::SLOT_W-1:0] found_index;
        logic [srtl_pkg::TAG_W-1:0]  found_tag;
    } lookup_result_t;

    typedef struct {
        srtl_pkg::op_t               operation;
        logic [srtl_pkg::SLOT_W-1:0] entry_index;
        logic [srtl_pkg::ADDR_W-1:0] range_low;
        logic [srtl_pkg::ADDR_W-1:0] range_high;
        logic [srtl_pkg::TAG_W-1:0]  library_tag;
        logic [srtl_pkg::ADDR_W-1:0] address;
    } table_item_t;

    class lookup_scoreboard;
        logic [srtl_pkg::ADDR_W-1:0] low_bound [srtl_pkg::MAX_RANGES];
        logic [srtl_pkg::ADDR_W-1:0] high_bound [srtl_pkg::MAX_RANGES];
        logic [srtl_pkg::TAG_W-1:0]  tag_of [srtl_pkg::MAX_RANGES];
        int unsigned       entry_count;
        bit                clear_low_bit;
        lookup_result_t    expected_results [$];
        int unsigned       mismatches;

        function new();
            entry_count   = 0;
            clear_low_bit = 0;
            mismatches    = 0;
        endfunction

        function int unsigned searched_count();
            return (entry_count > srtl_pkg::MAX_RANGES) ? srtl_pkg::MAX_RANGES : entry_count;
        endfunction

        // same probe order as the hardware search, first probed hit wins
        function lookup_result_t predict_lookup(logic [srtl_pkg::ADDR_W-1:0] address);
            lookup_result_t              r;
            logic [srtl_pkg::ADDR_W-1:0] key;
            int                          lo;
            int                          hi;
            int                          mid;
            r = '0;
            if (address == '0)
                return r;
            key = address;
            if (clear_low_bit)
                key[0] = 1'b0;
            lo = 0;
            hi = int'(searched_count()) - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (key < low_bound[mid])
                    hi = mid - 1;
                else if (key >= high_bound[mid])
                    lo = mid + 1;
                else
                begin
                    r.hit         = 1'b1;
                    r.found_index = mid[srtl_pkg::SLOT_W-1:0];
                    r.found_tag   = tag_of[mid];
                    return r;
                end
            end
            return r;
        endfunction

        function void note_item(table_item_t it);
            if (it.operation == srtl_pkg::OP_WRITE)
            begin
                low_bound[it.entry_index]  = it.range_low;
                high_bound[it.entry_index] = it.range_high;
                tag_of[it.entry_index]     = it.library_tag;
            end
            else
                expected_results.push_back(predict_lookup(it.address));
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result transfer: hit=%0d index=%0d tag=%h",
                             got.hit, got.found_index, got.found_tag);
                return;
            end
            want = expected_results.pop_front();
            if (got.hit !== want.hit || got.found_index !== want.found_index ||
                got.found_tag !== want.found_tag)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"lookup result differs: expected hit=%0d index=%0d tag=%h,",
                              " got hit=%0d index=%0d tag=%h"},
                             want.hit, want.found_index, want.found_tag,
                             got.hit, got.found_index, got.found_tag);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [srtl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [srtl_pkg::CFG_DATA_W-1:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    lookup_scoreboard sb;

    srtl_req_if req_ch();
    srtl_rsp_if rsp_ch();

    sorted_range_table_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #4 clk = ~clk;

    // result side: check every transfer, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.hit, rsp_ch.found_index, rsp_ch.found_tag});
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic table_item_t lookup_item(logic [srtl_pkg::ADDR_W-1:0] address);
        table_item_t it;
        it.operation   = srtl_pkg::OP_LOOKUP;
        it.entry_index = srtl_pkg::SLOT_W'($urandom_range(255));
        it.range_low   = {$urandom, $urandom};
        it.range_high  = {$urandom, $urandom};
        it.library_tag = srtl_pkg::TAG_W'($urandom_range(16'hFFFF));
        it.address     = address;
        return it;
    endfunction

    function automatic table_item_t write_item(int unsigned slot,
                                               logic [srtl_pkg::ADDR_W-1:0] lo,
                                               logic [srtl_pkg::ADDR_W-1:0] hi,
                                               logic [srtl_pkg::TAG_W-1:0] tag);
        table_item_t it;
        it.operation   = srtl_pkg::OP_WRITE;
        it.entry_index = slot[srtl_pkg::SLOT_W-1:0];
        it.range_low   = lo;
        it.range_high  = hi;
        it.library_tag = tag;
        it.address     = {$urandom, $urandom};
        return it;
    endfunction

    // slot s owns the address band whose top byte is s, so entries stay sorted
    function automatic void pick_interval(input int unsigned slot,
                                          output logic [srtl_pkg::ADDR_W-1:0] lo,
                                          output logic [srtl_pkg::ADDR_W-1:0] hi);
        logic [55:0] x;
        logic [55:0] y;
        x = 56'({$urandom, $urandom});
        y = 56'({$urandom, $urandom});
        if ($urandom_range(15) == 0)
            y = x;
        lo = {slot[7:0], ((x < y) ? x : y)};
        hi = {slot[7:0], ((x < y) ? y : x)};
    endfunction

    function automatic logic [srtl_pkg::ADDR_W-1:0] aimed_address();
        int unsigned                 n;
        int unsigned                 s;
        int unsigned                 pick;
        logic [srtl_pkg::ADDR_W-1:0] lo;
        logic [srtl_pkg::ADDR_W-1:0] hi;
        n = sb.searched_count();
        if (n == 0)
            n = srtl_pkg::MAX_RANGES;
        s    = $urandom_range(n - 1);
        lo   = sb.low_bound[s];
        hi   = sb.high_bound[s];
        pick = $urandom_range(99);
        if (pick < 8)
            return {$urandom, $urandom};
        if (pick < 12)
            return srtl_pkg::ADDR_W'($urandom_range(1));
        case (pick % 8)
            0: return lo;
            1: return hi;
            2: return hi - 1;
            3: return lo - 1;
            4: return lo + 1;
            default:
                if (hi > lo)
                    return lo + ({$urandom, $urandom} % (hi - lo));
                else
                    return lo;
        endcase
    endfunction

    task automatic send_item(input table_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= it.operation;
        req_ch.entry_index <= it.entry_index;
        req_ch.range_low   <= it.range_low;
        req_ch.range_high  <= it.range_high;
        req_ch.library_tag <= it.library_tag;
        req_ch.address     <= it.address;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        sb.note_item(it);
    endtask

    // sender holds off until every outstanding lookup has returned
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.expected_results.size() != 0);
    endtask

    // writes give no result, so let the pipeline empty before touching registers
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLE) @(posedge clk);
    endtask

    task automatic configure(input logic [srtl_pkg::CFG_DATA_W-1:0] count, input logic clear);
        cfg_write <= 1'b1;
        cfg_index <= srtl_pkg::REG_ENTRY_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_index <= srtl_pkg::REG_CLEAR_LOW_BIT;
        cfg_data  <= {{(srtl_pkg::CFG_DATA_W-1){1'b0}}, clear};
        @(posedge clk);
        cfg_write        <= 1'b0;
        sb.entry_count   = 32'(count);
        sb.clear_low_bit = clear;
    endtask

    task automatic fill_table();
        logic [srtl_pkg::ADDR_W-1:0] lo;
        logic [srtl_pkg::ADDR_W-1:0] hi;
        logic [srtl_pkg::TAG_W-1:0]  tag;
        for (int s = 0; s < srtl_pkg::MAX_RANGES; s++)
        begin
            pick_interval(s, lo, hi);
            tag = srtl_pkg::TAG_W'($urandom_range(16'hFFFF));
            if (s == 0)
            begin
                lo  = '0;
                hi  = hi | 64'h2;
                tag = '1;
            end
            if (s == srtl_pkg::MAX_RANGES - 1)
            begin
                hi  = '1;
                tag = '0;
            end
            send_item(write_item(s, lo, hi, tag));
        end
    endtask

    task automatic run_traffic(input int unsigned n_items);
        logic [srtl_pkg::ADDR_W-1:0] lo;
        logic [srtl_pkg::ADDR_W-1:0] hi;
        int unsigned                 pick;
        int unsigned                 slot;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                hold_until_drained();
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                slot = $urandom_range(srtl_pkg::MAX_RANGES - 1);
                if (pick < 3)
                begin
                    // noise: arbitrary bounds, may overlap or invert
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                else
                    pick_interval(slot, lo, hi);
                send_item(write_item(slot, lo, hi,
                                     srtl_pkg::TAG_W'($urandom_range(16'hFFFF))));
            end
            else
                send_item(lookup_item(aimed_address()));
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 33;
        recv_idle_pct = 71;
        rst_n              <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= srtl_pkg::REG_ENTRY_COUNT;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= srtl_pkg::OP_WRITE;
        req_ch.entry_index <= '0;
        req_ch.range_low   <= '0;
        req_ch.range_high  <= '0;
        req_ch.library_tag <= '0;
        req_ch.address     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: everything misses
        configure(9'd0, 1'b0);
        send_item(lookup_item(64'h0));
        send_item(lookup_item(64'h1));
        send_item(lookup_item('1));
        send_item(lookup_item(64'h8000_0000_0000_0000));
        fill_table();
        send_item(lookup_item(sb.low_bound[5]));
        send_item(lookup_item(64'h1));
        settle();

        // full table, thumb fix on
        configure(9'd256, 1'b1);
        send_item(lookup_item(64'h1));
        send_item(lookup_item(64'h0));
        send_item(lookup_item(sb.low_bound[128]));
        send_item(lookup_item(sb.high_bound[128] - 1));
        send_item(lookup_item(sb.high_bound[128]));
        send_item(lookup_item(sb.low_bound[77] | 64'h1));
        send_item(lookup_item(sb.low_bound[255]));
        send_item(lookup_item(64'hFFFF_FFFF_FFFF_FFFE));
        send_item(lookup_item('1));
        // empty and inverted intervals never match
        send_item(write_item(40, sb.low_bound[40], sb.low_bound[40], 16'h1234));
        send_item(write_item(41, sb.high_bound[41], sb.low_bound[41], 16'h4321));
        send_item(lookup_item(sb.low_bound[40]));
        send_item(lookup_item(sb.high_bound[41]));
        run_traffic(50);
        settle();

        // count beyond the table size is clamped
        configure(9'd511, 1'b0);
        run_traffic(50);
        settle();

        send_idle_pct = 71;
        recv_idle_pct = 33;
        configure(9'd1, 1'b1);
        run_traffic(30);
        settle();

        configure(9'd2, 1'b0);
        run_traffic(30);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(9'($urandom_range(255, 3)), 1'($urandom_range(1)));
        run_traffic(50);
        settle();

        configure(9'd256, 1'b0);
        run_traffic(50);
        settle();

        configure(9'd0, 1'b1);
        run_traffic(15);
        settle();

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("sorted_range_table_lookup: match");
        else
            $display("sorted_range_table_lookup: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("sorted_range_table_lookup: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/srtl_pkg.sv
hw/rtl/srtl_req_if.sv
hw/rtl/srtl_rsp_if.sv
hw/rtl/srtl_ram.sv
hw/rtl/srtl_cell.sv
hw/rtl/sorted_range_table_lookup.sv
tb/testbench.sv
